/* rtl/ru2_pkg.sv */
// Shared types and constants for the random 2x2 unitary generator.
package ru2_pkg;

    localparam int IN_BITS    = 16;
    localparam int OUT_BITS   = 16;
    localparam int ANG_W      = 32;
    localparam int TRIG_W     = 33;
    localparam int MAG_W      = 32;
    localparam int PROD_W     = MAG_W + TRIG_W + 1;
    localparam int STEPS      = 30;
    localparam int SQRT_STEPS = 32;
    localparam int CORE_DEPTH = STEPS + 3;
    localparam int PIPE_DEPTH = CORE_DEPTH + 2;

    localparam logic [30:0]              PI_Q29       = 31'd1686629713;
    localparam logic signed [TRIG_W-1:0] GAIN_INV_Q30 = 33'sd652032874;

    localparam logic signed [TRIG_W-1:0] ATAN_Q30 [STEPS] = '{
        33'sd843314856, 33'sd497837829, 33'sd263043836, 33'sd133525158, 33'sd67021686,
        33'sd33543515,  33'sd16775850,  33'sd8388437,   33'sd4194282,   33'sd2097149,
        33'sd1048575,   33'sd524287,    33'sd262143,    33'sd131071,    33'sd65535,
        33'sd32767,     33'sd16383,     33'sd8191,      33'sd4095,      33'sd2047,
        33'sd1023,      33'sd511,       33'sd255,       33'sd127,       33'sd63,
        33'sd31,        33'sd15,        33'sd7,         33'sd3,         33'sd1
    };

    typedef struct packed {
        logic [IN_BITS-1:0] u_alpha;
        logic [IN_BITS-1:0] u_phi;
        logic [IN_BITS-1:0] u_chi;
        logic [IN_BITS-1:0] u_psi;
    } req_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] m00_re;
        logic signed [OUT_BITS-1:0] m00_im;
        logic signed [OUT_BITS-1:0] m01_re;
        logic signed [OUT_BITS-1:0] m01_im;
        logic signed [OUT_BITS-1:0] m10_re;
        logic signed [OUT_BITS-1:0] m10_im;
        logic signed [OUT_BITS-1:0] m11_re;
        logic signed [OUT_BITS-1:0] m11_im;
    } res_t;

endpackage

/* rtl/ru2_cordic.sv */
// Pipelined turn-to-cosine/sine unit: reduction, radian scaling, CORDIC steps, quadrant fix, optional negation.
module ru2_cordic
    import ru2_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [ANG_W-1:0]         ang,
    input  logic                     neg,
    output logic signed [TRIG_W-1:0] cos_out,
    output logic signed [TRIG_W-1:0] sin_out
);

    localparam logic [ANG_W-1:0] QUARTER_HALF = ANG_W'(32'h2000_0000);

    logic [ANG_W-1:0]  t_next;
    logic signed [30:0] r_next;
    logic [29:0]       rabs_next;
    logic [29:0]       rabs_reg;
    logic              rneg_reg;
    logic [1:0]        q0_reg;
    logic              neg0_reg;

    logic [60:0]       rad_prod;
    logic [30:0]       rad_mag;

    logic signed [TRIG_W-1:0] x_reg [STEPS+1];
    logic signed [TRIG_W-1:0] y_reg [STEPS+1];
    logic signed [TRIG_W-1:0] z_reg [STEPS+1];
    logic [1:0]               q_reg [STEPS+1];
    logic                     n_reg [STEPS+1];

    logic signed [TRIG_W-1:0] c_next, s_next, c_reg, s_reg;

    always_comb
    begin
        t_next    = ang + QUARTER_HALF;
        r_next    = $signed({1'b0, t_next[29:0]}) - 31'sd536870912;
        rabs_next = r_next[30] ? 30'(-r_next) : r_next[29:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rabs_reg <= rabs_next;
            rneg_reg <= r_next[30];
            q0_reg   <= t_next[31:30];
            neg0_reg <= neg;
        end
    end

    assign rad_prod = 61'(rabs_reg) * 61'(PI_Q29) + 61'(64'd1 << 29);
    assign rad_mag  = rad_prod[60:30];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= GAIN_INV_Q30;
            y_reg[0] <= '0;
            z_reg[0] <= rneg_reg ? -$signed({2'b00, rad_mag}) : $signed({2'b00, rad_mag});
            q_reg[0] <= q0_reg;
            n_reg[0] <= neg0_reg;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic signed [TRIG_W-1:0] dx, dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][TRIG_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - ATAN_Q30[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + ATAN_Q30[i];
                end
                q_reg[i+1] <= q_reg[i];
                n_reg[i+1] <= n_reg[i];
            end
        end
    end

    always_comb
    begin
        unique case (q_reg[STEPS])
            2'd0:
            begin
                c_next = x_reg[STEPS];
                s_next = y_reg[STEPS];
            end
            2'd1:
            begin
                c_next = -y_reg[STEPS];
                s_next = x_reg[STEPS];
            end
            2'd2:
            begin
                c_next = -x_reg[STEPS];
                s_next = -y_reg[STEPS];
            end
            default:
            begin
                c_next = y_reg[STEPS];
                s_next = -x_reg[STEPS];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= n_reg[STEPS] ? -c_next : c_next;
            s_reg <= n_reg[STEPS] ? -s_next : s_next;
        end
    end

    assign cos_out = c_reg;
    assign sin_out = s_reg;

endmodule

/* rtl/ru2_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
module ru2_sqrt
    import ru2_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [63:0]      n,
    output logic [MAG_W-1:0] root
);

    logic [63:0] rem_reg  [SQRT_STEPS+1];
    logic [63:0] root_reg [SQRT_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= n;
            root_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_bit
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] trial;
        assign trial = root_reg[k] + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_reg[k] >= trial)
                begin
                    rem_reg[k+1]  <= rem_reg[k] - trial;
                    root_reg[k+1] <= (root_reg[k] >> 1) + BIT;
                end
                else
                begin
                    rem_reg[k+1]  <= rem_reg[k];
                    root_reg[k+1] <= root_reg[k] >> 1;
                end
            end
        end
    end

    assign root = root_reg[SQRT_STEPS][MAG_W-1:0];

endmodule

/* rtl/ru2_scale.sv */
// Magnitude times trig product, rounding and saturation to the output format.
module ru2_scale
    import ru2_pkg::*;
(
    input  logic                       clk,
    input  logic                       en,
    input  logic [MAG_W-1:0]           mag,
    input  logic signed [TRIG_W-1:0]   trig,
    output logic signed [OUT_BITS-1:0] part
);

    localparam int SH = 62 - OUT_BITS;
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (SH - 1);
    localparam logic signed [PROD_W-1:0] LIM  = (PROD_W'(1) <<< (OUT_BITS - 1)) - PROD_W'(1);

    logic signed [PROD_W-1:0]   p_reg;
    logic signed [PROD_W-1:0]   v;
    logic signed [OUT_BITS-1:0] part_next, part_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= $signed({1'b0, mag}) * trig;
        end
    end

    always_comb
    begin
        v = (p_reg + HALF) >>> SH;
        priority if (v > LIM)
            part_next = LIM[OUT_BITS-1:0];
        else if (v < -LIM)
            part_next = -LIM[OUT_BITS-1:0];
        else
            part_next = v[OUT_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            part_reg <= part_next;
        end
    end

    assign part = part_reg;

endmodule

/* rtl/random_unitary_2x2_from_uniforms.sv */
// Top level: random 2x2 unitary matrix from four uniform fractions.
// One request is accepted every clock while the result side is not stalled; each request
// gives one result through the 30-step CORDIC and 32-step square-root pipelines run side
// by side, plus multiply and rounding stages. A result stall while res_valid is high
// freezes the whole pipeline in place, and stall is raised then.
module random_unitary_2x2_from_uniforms
    import ru2_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic valid,
    output logic stall,
    input  req_t req,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    localparam int UP = ANG_W - IN_BITS;
    localparam int SQ = 62 - IN_BITS;

    logic                     en;
    logic                     valid_reg [PIPE_DEPTH];
    logic [ANG_W-1:0]         al, ph, ch;
    logic [63:0]              n_sin, n_cos;
    logic [ANG_W-1:0]         ang [4];
    logic                     neg [4];
    logic signed [TRIG_W-1:0] c   [4];
    logic signed [TRIG_W-1:0] s   [4];
    logic [MAG_W-1:0]         sinp, cosp;
    logic [MAG_W-1:0]         mag [4];
    logic signed [OUT_BITS-1:0] re [4];
    logic signed [OUT_BITS-1:0] im [4];

    assign en    = !(valid_reg[PIPE_DEPTH-1] && res_stall);
    assign stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE_DEPTH; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= valid;
            for (int k = 1; k < PIPE_DEPTH; k++)
                valid_reg[k] <= valid_reg[k-1];
        end
    end

    assign al = ANG_W'(req.u_alpha) << UP;
    assign ph = ANG_W'(req.u_phi) << UP;
    assign ch = ANG_W'(req.u_chi) << UP;

    assign n_sin = 64'(req.u_psi) << SQ;
    assign n_cos = ((64'd1 << IN_BITS) - 64'(req.u_psi)) << SQ;

    assign ang[0] = al + ph;
    assign ang[1] = al + ch;
    assign ang[2] = al - ch;
    assign ang[3] = al - ph;
    assign neg[0] = 1'b0;
    assign neg[1] = 1'b0;
    assign neg[2] = 1'b1;
    assign neg[3] = 1'b0;

    ru2_sqrt u_sqrt_sin (.clk(clk), .en(en), .n(n_sin), .root(sinp));
    ru2_sqrt u_sqrt_cos (.clk(clk), .en(en), .n(n_cos), .root(cosp));

    assign mag[0] = cosp;
    assign mag[1] = sinp;
    assign mag[2] = sinp;
    assign mag[3] = cosp;

    for (genvar e = 0; e < 4; e++)
    begin : g_entry
        ru2_cordic u_cordic (
            .clk(clk), .en(en), .ang(ang[e]), .neg(neg[e]),
            .cos_out(c[e]), .sin_out(s[e])
        );
        ru2_scale u_re (.clk(clk), .en(en), .mag(mag[e]), .trig(c[e]), .part(re[e]));
        ru2_scale u_im (.clk(clk), .en(en), .mag(mag[e]), .trig(s[e]), .part(im[e]));
    end

    assign res_valid  = valid_reg[PIPE_DEPTH-1];
    assign res.m00_re = re[0];
    assign res.m00_im = im[0];
    assign res.m01_re = re[1];
    assign res.m01_im = im[1];
    assign res.m10_re = re[2];
    assign res.m10_im = im[2];
    assign res.m11_re = re[3];
    assign res.m11_im = im[3];

endmodule
